FILE: rtl/core/tlx_pkg.sv
// ----------------------------------------------------------------------------
// Token lexer package
// Shared widths, token kind codes and the control structs that link the
// token queue with the front end and the back end.
// ----------------------------------------------------------------------------
package tlx_pkg;

    localparam int DEF_POSITION_WIDTH = 16;
    localparam int DEF_VALUE_WIDTH    = 32;
    localparam int KIND_W             = 5;
    localparam int QUEUE_DEPTH        = 4;
    localparam int PREFIX_BYTES       = 5;

    localparam logic [KIND_W-1:0] KIND_NUMBER    = 5'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT     = 5'd1;
    localparam logic [KIND_W-1:0] KIND_FN        = 5'd2;
    localparam logic [KIND_W-1:0] KIND_LET       = 5'd3;
    localparam logic [KIND_W-1:0] KIND_IF        = 5'd4;
    localparam logic [KIND_W-1:0] KIND_WHILE     = 5'd5;
    localparam logic [KIND_W-1:0] KIND_EQ_EQ     = 5'd6;
    localparam logic [KIND_W-1:0] KIND_PLUS      = 5'd10;
    localparam logic [KIND_W-1:0] KIND_MINUS     = 5'd11;
    localparam logic [KIND_W-1:0] KIND_STAR      = 5'd12;
    localparam logic [KIND_W-1:0] KIND_SLASH     = 5'd13;
    localparam logic [KIND_W-1:0] KIND_PERCENT   = 5'd14;
    localparam logic [KIND_W-1:0] KIND_ASSIGN    = 5'd15;
    localparam logic [KIND_W-1:0] KIND_LESS      = 5'd16;
    localparam logic [KIND_W-1:0] KIND_GREATER   = 5'd17;
    localparam logic [KIND_W-1:0] KIND_LBRACE    = 5'd18;
    localparam logic [KIND_W-1:0] KIND_RBRACE    = 5'd19;
    localparam logic [KIND_W-1:0] KIND_LPAREN    = 5'd20;
    localparam logic [KIND_W-1:0] KIND_RPAREN    = 5'd21;
    localparam logic [KIND_W-1:0] KIND_COMMA     = 5'd22;
    localparam logic [KIND_W-1:0] KIND_SEMICOLON = 5'd23;
    localparam logic [KIND_W-1:0] KIND_END       = 5'd24;
    localparam logic [KIND_W-1:0] KIND_ERROR     = 5'd25;

    localparam logic [1:0] SIGN_EQ   = 2'd0;
    localparam logic [1:0] SIGN_BANG = 2'd1;
    localparam logic [1:0] SIGN_LT   = 2'd2;
    localparam logic [1:0] SIGN_GT   = 2'd3;

    typedef struct packed {
        logic w0;
        logic w1;
    } q_write_t;

    typedef struct packed {
        logic has_data;
        logic has_room;
    } q_status_t;

    function automatic int data_bits(input int value_width, input int position_width);
        data_bits = KIND_W + value_width + 2 * position_width + 1;
    endfunction

    function automatic int tdata_bits(input int value_width, input int position_width);
        tdata_bits = ((data_bits(value_width, position_width) + 7) / 8) * 8;
    endfunction

endpackage

FILE: rtl/core/tlx_front.sv
// ----------------------------------------------------------------------------
// Token lexer front end
// Accepts one source byte per cycle with accept high, tracks the pending
// token and writes zero, one or two finished token records into the queue.
// ----------------------------------------------------------------------------
module tlx_front #(
    parameter int POSITION_WIDTH = tlx_pkg::DEF_POSITION_WIDTH,
    parameter int VALUE_WIDTH    = tlx_pkg::DEF_VALUE_WIDTH,
    parameter int REC_W          = tlx_pkg::tdata_bits(VALUE_WIDTH, POSITION_WIDTH) + 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       text_byte,
    output tlx_pkg::q_write_t wr,
    output logic [REC_W-1:0] rec0,
    output logic [REC_W-1:0] rec1
);
    import tlx_pkg::*;

    localparam int P        = POSITION_WIDTH;
    localparam int V        = VALUE_WIDTH;
    localparam int OFF_VAL  = KIND_W;
    localparam int OFF_ST   = OFF_VAL + V;
    localparam int OFF_LEN  = OFF_ST + P;
    localparam int OFF_OVF  = OFF_LEN + P;
    localparam int PW       = 8 * PREFIX_BYTES;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_SIGN
    } mode_t;

    mode_t          mode_reg, mode_next;
    logic [1:0]     sign_reg, sign_next;
    logic [V-1:0]   acc_reg, acc_next;
    logic [PW-1:0]  prefix_reg, prefix_next;
    logic [P-1:0]   start_reg, start_next;
    logic [P-1:0]   count_reg, count_next;
    logic [P-1:0]   pos_reg, pos_next;
    logic           sat_reg, sat_next;

    logic           is_digit, is_letter, is_word, is_space, is_sign;
    logic [3:0]     digit;
    logic [1:0]     sign_code;
    logic           single_hit;
    logic [KIND_W-1:0] single_kind;
    logic [V+3:0]   acc_ten;
    logic           acc_ovf;
    logic [P-1:0]   count_inc;
    logic [P-1:0]   pos_inc;
    logic [KIND_W-1:0] word_kind;

    logic              done;
    logic              c_v;
    logic [KIND_W-1:0] c_kind;
    logic [V-1:0]      c_val;
    logic [P-1:0]      c_start;
    logic [P-1:0]      c_len;
    logic              c_ovf;
    logic              t_v;
    logic [KIND_W-1:0] t_kind;

    always_comb begin
        is_digit  = (text_byte >= "0") && (text_byte <= "9");
        is_letter = ((text_byte >= "a") && (text_byte <= "z"))
                 || ((text_byte >= "A") && (text_byte <= "Z"));
        is_word   = is_letter || is_digit || (text_byte == "_");
        is_space  = (text_byte == " ") || ((text_byte >= 8'd9) && (text_byte <= 8'd13));
        digit     = 4'(text_byte - "0");
        is_sign   = 1'b1;
        sign_code = SIGN_EQ;
        case (text_byte)
            "=":     sign_code = SIGN_EQ;
            "!":     sign_code = SIGN_BANG;
            "<":     sign_code = SIGN_LT;
            ">":     sign_code = SIGN_GT;
            default: is_sign = 1'b0;
        endcase
        single_hit  = 1'b1;
        single_kind = KIND_ERROR;
        case (text_byte)
            "+":     single_kind = KIND_PLUS;
            "-":     single_kind = KIND_MINUS;
            "*":     single_kind = KIND_STAR;
            "/":     single_kind = KIND_SLASH;
            "%":     single_kind = KIND_PERCENT;
            "{":     single_kind = KIND_LBRACE;
            "}":     single_kind = KIND_RBRACE;
            "(":     single_kind = KIND_LPAREN;
            ")":     single_kind = KIND_RPAREN;
            ",":     single_kind = KIND_COMMA;
            ";":     single_kind = KIND_SEMICOLON;
            default: single_hit = 1'b0;
        endcase

        acc_ten   = {acc_reg, 3'b000} + {1'b0, acc_reg, 2'b00} - {2'b00, acc_reg, 2'b00}
                  + {2'b00, acc_reg, 1'b0} + (V + 4)'(digit);
        acc_ovf   = sat_reg || (acc_ten[V+3:V] != 4'd0);
        count_inc = (&count_reg) ? count_reg : count_reg + 1'b1;
        pos_inc   = pos_reg + 1'b1;

        word_kind = KIND_IDENT;
        if ((count_reg == P'(2)) && (prefix_reg == 40'h00_0000_6E66)) begin
            word_kind = KIND_FN;
        end else if ((count_reg == P'(3)) && (prefix_reg == 40'h00_0074_656C)) begin
            word_kind = KIND_LET;
        end else if ((count_reg == P'(2)) && (prefix_reg == 40'h00_0000_6669)) begin
            word_kind = KIND_IF;
        end else if ((count_reg == P'(5)) && (prefix_reg == 40'h65_6C69_6877)) begin
            word_kind = KIND_WHILE;
        end
    end

    always_comb begin
        mode_next   = mode_reg;
        sign_next   = sign_reg;
        acc_next    = acc_reg;
        prefix_next = prefix_reg;
        start_next  = start_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        sat_next    = sat_reg;
        done        = 1'b0;
        c_v         = 1'b0;
        c_kind      = KIND_NUMBER;
        c_val       = '0;
        c_start     = start_reg;
        c_len       = count_reg;
        c_ovf       = 1'b0;
        t_v         = 1'b0;
        t_kind      = KIND_ERROR;

        case (mode_reg)
            MODE_NUMBER: begin
                if (is_digit) begin
                    acc_next   = acc_ovf ? {V{1'b1}} : acc_ten[V-1:0];
                    sat_next   = acc_ovf;
                    count_next = count_inc;
                    pos_next   = pos_inc;
                    done       = 1'b1;
                end else begin
                    c_v    = 1'b1;
                    c_kind = KIND_NUMBER;
                    c_val  = acc_reg;
                    c_ovf  = sat_reg;
                end
            end
            MODE_IDENT: begin
                if (is_word) begin
                    for (int i = 0; i < PREFIX_BYTES; i++) begin
                        if (count_reg == P'(i)) begin
                            prefix_next[8*i +: 8] = text_byte;
                        end
                    end
                    count_next = count_inc;
                    pos_next   = pos_inc;
                    done       = 1'b1;
                end else begin
                    c_v    = 1'b1;
                    c_kind = word_kind;
                end
            end
            MODE_SIGN: begin
                c_v   = 1'b1;
                c_len = P'(1);
                if (text_byte == "=") begin
                    c_kind    = KIND_EQ_EQ + KIND_W'(sign_reg);
                    c_len     = P'(2);
                    mode_next = MODE_IDLE;
                    pos_next  = pos_inc;
                    done      = 1'b1;
                end else if (sign_reg == SIGN_BANG) begin
                    c_kind    = KIND_ERROR;
                    mode_next = MODE_IDLE;
                    sign_next = SIGN_EQ;
                    pos_next  = '0;
                    done      = 1'b1;
                end else begin
                    case (sign_reg)
                        SIGN_EQ: c_kind = KIND_ASSIGN;
                        SIGN_LT: c_kind = KIND_LESS;
                        default: c_kind = KIND_GREATER;
                    endcase
                end
            end
            default: ;
        endcase

        if (!done) begin
            mode_next  = MODE_IDLE;
            start_next = pos_reg;
            pos_next   = pos_inc;
            if (is_space) begin
                mode_next = MODE_IDLE;
            end else if (is_digit) begin
                mode_next  = MODE_NUMBER;
                acc_next   = V'(digit);
                sat_next   = 1'b0;
                count_next = P'(1);
            end else if (is_letter || (text_byte == "_")) begin
                mode_next   = MODE_IDENT;
                prefix_next = PW'(text_byte);
                count_next  = P'(1);
            end else if (is_sign) begin
                mode_next  = MODE_SIGN;
                sign_next  = sign_code;
                count_next = P'(1);
            end else if (single_hit) begin
                t_v    = 1'b1;
                t_kind = single_kind;
            end else begin
                t_v       = 1'b1;
                t_kind    = (text_byte == 8'd0) ? KIND_END : KIND_ERROR;
                sign_next = SIGN_EQ;
                pos_next  = '0;
            end
        end
    end

    always_comb begin
        rec0 = '0;
        rec1 = '0;
        if (c_v) begin
            rec0[KIND_W-1:0]        = c_kind;
            rec0[OFF_VAL +: V]      = c_val;
            rec0[OFF_ST +: P]       = c_start;
            rec0[OFF_LEN +: P]      = c_len;
            rec0[OFF_OVF]           = c_ovf;
            rec0[REC_W-1]           = !t_v;
            rec1[KIND_W-1:0]        = t_kind;
            rec1[OFF_ST +: P]       = pos_reg;
            rec1[OFF_LEN +: P]      = P'(1);
            rec1[REC_W-1]           = 1'b1;
        end else begin
            rec0[KIND_W-1:0]        = t_kind;
            rec0[OFF_ST +: P]       = pos_reg;
            rec0[OFF_LEN +: P]      = P'(1);
            rec0[REC_W-1]           = 1'b1;
        end
        wr.w0 = accept && (c_v || t_v);
        wr.w1 = accept && c_v && t_v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            sign_reg   <= SIGN_EQ;
            acc_reg    <= '0;
            prefix_reg <= '0;
            start_reg  <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
            sat_reg    <= 1'b0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            sign_reg   <= sign_next;
            acc_reg    <= acc_next;
            prefix_reg <= prefix_next;
            start_reg  <= start_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            sat_reg    <= sat_next;
        end
    end

endmodule

FILE: rtl/core/tlx_queue.sv
// ----------------------------------------------------------------------------
// Token lexer queue
// Small token record queue with two write slots per cycle and one read.
// ----------------------------------------------------------------------------
module tlx_queue #(
    parameter int REC_W = 73
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tlx_pkg::q_write_t wr,
    input  logic [REC_W-1:0]  rec0,
    input  logic [REC_W-1:0]  rec1,
    input  logic              pop,
    output tlx_pkg::q_status_t status,
    output logic [REC_W-1:0]  head
);
    import tlx_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [REC_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]    wptr_reg, wptr_next;
    logic [AW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    waddr1;

    always_comb begin
        waddr1     = wptr_reg + 1'b1;
        wptr_next  = wptr_reg + AW'(wr.w0) + AW'(wr.w1);
        rptr_next  = rptr_reg + AW'(pop);
        count_next = count_reg + CW'(wr.w0) + CW'(wr.w1) - CW'(pop);
        status.has_data = (count_reg != '0);
        status.has_room = (count_reg <= CW'(QUEUE_DEPTH - 2));
        head = mem_reg[rptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (wr.w0) begin
            mem_reg[wptr_reg] <= rec0;
        end
        if (wr.w1) begin
            mem_reg[waddr1] <= rec1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/core/tlx_back.sv
// ----------------------------------------------------------------------------
// Token lexer back end
// Takes token records from the queue into the output register and offers
// them on the result stream.
// ----------------------------------------------------------------------------
module tlx_back #(
    parameter int REC_W = 73
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tlx_pkg::q_status_t status,
    input  logic [REC_W-1:0]   head,
    output logic               pop,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [REC_W-2:0]   m_axis_tdata,
    output logic               m_axis_tlast
);
    import tlx_pkg::*;

    logic             valid_reg, valid_next;
    logic [REC_W-1:0] rec_reg;

    always_comb begin
        pop        = status.has_data && (!valid_reg || m_axis_tready);
        valid_next = pop || (valid_reg && !m_axis_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            rec_reg <= head;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = rec_reg[REC_W-2:0];
    assign m_axis_tlast  = rec_reg[REC_W-1];

endmodule

FILE: rtl/core/token_lexer_top.sv
// ----------------------------------------------------------------------------
// Token lexer top level
// Streaming maximal-munch lexer: source bytes in, token records out.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata: text_byte
//   m_axis   out        tdata: token_kind, number_value, start_position,
//                              token_length, value_overflow; tlast: last_of_run
//
// One byte is accepted per cycle while the token queue has room for two
// records. A token passes through the queue and then the output register
// before leaving. A byte yielding two tokens writes both together; since every
// token spans at least one byte, an always-ready output keeps the queue at two
// entries or fewer and the input never waits. Reset is synchronous and clears
// the scanner, queue and output register. A stalled output fills the
// four-entry queue past two entries and then holds off the input.
// ----------------------------------------------------------------------------
module token_lexer_top #(
    parameter int POSITION_WIDTH = tlx_pkg::DEF_POSITION_WIDTH,
    parameter int VALUE_WIDTH    = tlx_pkg::DEF_VALUE_WIDTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    // text_byte [7:0]
    input  logic [7:0] s_axis_tdata,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    // token_kind, number_value, start_position, token_length, value_overflow,
    // zero fill up to a whole byte
    output logic [tlx_pkg::tdata_bits(VALUE_WIDTH, POSITION_WIDTH)-1:0] m_axis_tdata,
    // last_of_run
    output logic       m_axis_tlast
);
    import tlx_pkg::*;

    localparam int REC_W = tdata_bits(VALUE_WIDTH, POSITION_WIDTH) + 1;

    q_write_t         wr;
    q_status_t        status;
    logic [REC_W-1:0] rec0;
    logic [REC_W-1:0] rec1;
    logic [REC_W-1:0] head;
    logic             pop;
    logic             accept;

    assign s_axis_tready = status.has_room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    tlx_front #(
        .POSITION_WIDTH(POSITION_WIDTH),
        .VALUE_WIDTH   (VALUE_WIDTH),
        .REC_W         (REC_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .text_byte(s_axis_tdata),
        .wr       (wr),
        .rec0     (rec0),
        .rec1     (rec1)
    );

    tlx_queue #(
        .REC_W(REC_W)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr     (wr),
        .rec0   (rec0),
        .rec1   (rec1),
        .pop    (pop),
        .status (status),
        .head   (head)
    );

    tlx_back #(
        .REC_W(REC_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .status       (status),
        .head         (head),
        .pop          (pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    a_second_write_needs_first: assert property (
        @(posedge aclk) disable iff (!aresetn) wr.w1 |-> wr.w0
    ) else $error("Second queue write without the first.");

    a_write_fills_queue: assert property (
        @(posedge aclk) disable iff (!aresetn) (wr.w0 && !status.has_data) |=> status.has_data
    ) else $error("Queue still empty after a token write.");

    a_head_moves_to_output: assert property (
        @(posedge aclk) disable iff (!aresetn) (status.has_data && !m_axis_tvalid) |=> m_axis_tvalid
    ) else $error("Queued token did not reach the output register.");

endmodule

FILE: tb/token_lexer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token lexer checker
// Watches the byte and token streams of the lexer. For every accepted source
// byte it works out the tokens that the byte closes or emits, and it compares
// every token that leaves the block, field by field, with the oldest token
// still waiting. Unexpected tokens and wrong fields are counted as failures.
// ----------------------------------------------------------------------------
module token_lexer_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [tlx_pkg::tdata_bits(tlx_pkg::DEF_VALUE_WIDTH,
                                      tlx_pkg::DEF_POSITION_WIDTH)-1:0] m_axis_tdata,
    input  logic       m_axis_tlast,
    output int         fail_count,
    output int         outstanding
);
    import tlx_pkg::*;

    localparam int VW = DEF_VALUE_WIDTH;
    localparam int PW = DEF_POSITION_WIDTH;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VW-1:0]     value;
        logic [PW-1:0]     start;
        logic [PW-1:0]     length;
        logic              overflow;
        logic              last;
    } token_t;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_NUMBER,
        SCAN_WORD,
        SCAN_SIGN
    } scan_t;

    scan_t         mode;
    logic [1:0]    sign;
    logic [VW-1:0] acc;
    logic [39:0]   prefix;
    logic [PW-1:0] tok_start;
    logic [PW-1:0] tok_len;
    logic [PW-1:0] offset;
    logic          saturated;

    token_t step_tokens[$];
    token_t pending_tokens[$];

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_letter(b) || is_digit(b) || b == "_";
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] b);
        case (b)
            "+": return KIND_PLUS;
            "-": return KIND_MINUS;
            "*": return KIND_STAR;
            "/": return KIND_SLASH;
            "%": return KIND_PERCENT;
            "{": return KIND_LBRACE;
            "}": return KIND_RBRACE;
            "(": return KIND_LPAREN;
            ")": return KIND_RPAREN;
            ",": return KIND_COMMA;
            ";": return KIND_SEMICOLON;
            default: return KIND_NUMBER;
        endcase
    endfunction

    // The prefix keeps the first byte lowest, so the keywords read backwards.
    function automatic logic [KIND_W-1:0] word_kind();
        if (tok_len == 2 && prefix == 40'("nf")) return KIND_FN;
        if (tok_len == 3 && prefix == 40'("tel")) return KIND_LET;
        if (tok_len == 2 && prefix == 40'("fi")) return KIND_IF;
        if (tok_len == 5 && prefix == 40'("elihw")) return KIND_WHILE;
        return KIND_IDENT;
    endfunction

    task automatic clear_state();
        mode      = SCAN_IDLE;
        sign      = SIGN_EQ;
        acc       = '0;
        prefix    = '0;
        tok_start = '0;
        tok_len   = '0;
        offset    = '0;
        saturated = 1'b0;
    endtask

    task automatic emit(input logic [KIND_W-1:0] kind, input logic [VW-1:0] value,
                        input logic [PW-1:0] start, input logic [PW-1:0] length,
                        input logic overflow);
        token_t t;
        t.kind     = kind;
        t.value    = value;
        t.start    = start;
        t.length   = length;
        t.overflow = overflow;
        t.last     = 1'b0;
        step_tokens.push_back(t);
    endtask

    task automatic scan_byte(input logic [7:0] b);
        logic [PW-1:0]     here;
        logic [VW+3:0]     grown;
        logic [KIND_W-1:0] single;
        here = offset;
        if (mode == SCAN_NUMBER) begin
            if (is_digit(b)) begin
                grown = {4'b0, acc} * 4'd10 + b[3:0];
                if (saturated || grown > {4'b0, {VW{1'b1}}}) begin
                    acc       = '1;
                    saturated = 1'b1;
                end else begin
                    acc = grown[VW-1:0];
                end
                if (tok_len != '1) tok_len = tok_len + 1'b1;
                offset = here + 1'b1;
                return;
            end
            emit(KIND_NUMBER, acc, tok_start, tok_len, saturated);
            mode = SCAN_IDLE;
        end else if (mode == SCAN_WORD) begin
            if (is_word(b)) begin
                if (tok_len < PREFIX_BYTES) prefix[8*tok_len +: 8] = b;
                if (tok_len != '1) tok_len = tok_len + 1'b1;
                offset = here + 1'b1;
                return;
            end
            emit(word_kind(), '0, tok_start, tok_len, 1'b0);
            mode = SCAN_IDLE;
        end else if (mode == SCAN_SIGN) begin
            if (b == "=") begin
                emit(KIND_EQ_EQ + sign, '0, tok_start, PW'(2), 1'b0);
                mode   = SCAN_IDLE;
                offset = here + 1'b1;
                return;
            end
            if (sign == SIGN_BANG) begin
                emit(KIND_ERROR, '0, tok_start, PW'(1), 1'b0);
                clear_state();
                return;
            end
            emit(sign == SIGN_EQ ? KIND_ASSIGN : (sign == SIGN_LT ? KIND_LESS : KIND_GREATER),
                 '0, tok_start, PW'(1), 1'b0);
            mode = SCAN_IDLE;
        end

        tok_start = here;
        single    = single_kind(b);
        if (!is_space(b)) begin
            if (is_digit(b)) begin
                mode      = SCAN_NUMBER;
                acc       = {{(VW-4){1'b0}}, b[3:0]};
                saturated = 1'b0;
                tok_len   = PW'(1);
            end else if (is_letter(b) || b == "_") begin
                mode    = SCAN_WORD;
                prefix  = {32'b0, b};
                tok_len = PW'(1);
            end else if (b == "=" || b == "!" || b == "<" || b == ">") begin
                mode    = SCAN_SIGN;
                sign    = b == "=" ? SIGN_EQ : (b == "!" ? SIGN_BANG :
                          (b == "<" ? SIGN_LT : SIGN_GT));
                tok_len = PW'(1);
            end else if (single != KIND_NUMBER) begin
                emit(single, '0, here, PW'(1), 1'b0);
            end else begin
                emit(b == 8'd0 ? KIND_END : KIND_ERROR, '0, here, PW'(1), 1'b0);
                clear_state();
                return;
            end
        end
        offset = here + 1'b1;
    endtask

    task automatic lex_byte(input logic [7:0] b);
        step_tokens.delete();
        scan_byte(b);
        if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
    endtask

    task automatic check_token(input token_t got);
        token_t want;
        if (pending_tokens.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: unexpected token: kind %0d value %0d start %0d length %0d ",
                         $realtime, got.kind, got.value, got.start, got.length,
                         "ovf %0b last %0b", got.overflow, got.last);
            return;
        end
        want = pending_tokens.pop_front();
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: token mismatch: expected kind %0d value %0d start %0d ",
                         $realtime, want.kind, want.value, want.start,
                         "length %0d ovf %0b last %0b, got kind %0d value %0d start %0d ",
                         want.length, want.overflow, want.last, got.kind, got.value,
                         got.start, "length %0d ovf %0b last %0b",
                         got.length, got.overflow, got.last);
        end
    endtask

    always @(posedge aclk) begin
        token_t got;
        if (!aresetn) begin
            clear_state();
            pending_tokens.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind     = m_axis_tdata[KIND_W-1:0];
                got.value    = m_axis_tdata[KIND_W +: VW];
                got.start    = m_axis_tdata[KIND_W+VW +: PW];
                got.length   = m_axis_tdata[KIND_W+VW+PW +: PW];
                got.overflow = m_axis_tdata[KIND_W+VW+2*PW];
                got.last     = m_axis_tlast;
                check_token(got);
            end
            if (s_axis_tvalid && s_axis_tready) lex_byte(s_axis_tdata);
        end
        outstanding = pending_tokens.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token lexer testbench
// Feeds the lexer a short hand-written program set that touches every token
// kind and special case, and then random programs built from well-formed
// tokens mixed with noise. Both streams stall in random bursts.
// A separate checker predicts and compares the tokens.
// ----------------------------------------------------------------------------
module testbench;
    import tlx_pkg::*;

    localparam int TDATA_W      = tdata_bits(DEF_VALUE_WIDTH, DEF_POSITION_WIDTH);
    localparam int RANDOM_BYTES = 1780;
    localparam int CALM_BYTES   = 200;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic [7:0]         s_axis_tdata  = 8'd0;
    logic               m_axis_tready = 1'b0;
    logic               s_axis_tready;
    logic               m_axis_tvalid;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;
    int                 fail_count;
    int                 outstanding;

    logic       calm       = 1'b0;
    int         stall_left = 0;
    int         random_sent;
    logic [7:0] text_q[$];

    string near_words[12] = '{"fn", "let", "if", "while", "whil", "whilex",
                              "Fn", "lets", "iff", "f", "le", "_if"};
    string singles = "+-*/%=<>{}(),;";
    string doubles[4] = '{"==", "!=", "<=", ">="};

    token_lexer_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    token_lexer_checker token_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always #10 aclk = ~aclk;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 10);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        #40_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return "_";
    endfunction

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(9, 14);
        return r == 14 ? 8'd32 : 8'(r);
    endfunction

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    task automatic add_token();
        int   n;
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1: begin
                if ($urandom_range(0, 15) == 0) begin
                    add_str($urandom_range(0, 1) ? "4294967295" : "4294967296");
                end else begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) :
                        $urandom_range(1, 4);
                    repeat (n) text_q.push_back(8'("0" + $urandom_range(0, 9)));
                end
            end
            2, 3: begin
                do c = word_char(); while (c >= "0" && c <= "9");
                text_q.push_back(c);
                repeat ($urandom_range(0, 7)) text_q.push_back(word_char());
            end
            4: add_str(near_words[$urandom_range(0, 11)]);
            5: add_str(doubles[$urandom_range(0, 3)]);
            6, 7, 8: text_q.push_back(singles[$urandom_range(0, singles.len() - 1)]);
            default: begin
                case ($urandom_range(0, 3))
                    0: text_q.push_back(8'($urandom_range(0, 255)));
                    1: begin
                        text_q.push_back("!");
                        text_q.push_back(8'($urandom_range(0, 255)));
                    end
                    2: text_q.push_back(8'($urandom_range(128, 255)));
                    default: repeat ($urandom_range(1, 3)) text_q.push_back(blank_char());
                endcase
            end
        endcase
        if ($urandom_range(0, 1)) repeat ($urandom_range(1, 2)) text_q.push_back(blank_char());
    endtask

    task automatic add_program();
        repeat ($urandom_range(1, 14)) add_token();
        if ($urandom_range(0, 7) != 0) text_q.push_back(8'd0);
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic send_text();
        while (text_q.size() > 0) send_byte(text_q.pop_front());
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        add_str("fn+let-if*while/_9%7{(==)!=}<=,>=;=<>");
        text_q.push_back(8'd0);
        add_str("4294967295 4294967296\t!ax");
        text_q.push_back(8'h80);
        add_str("12");
        text_q.push_back(8'hFF);
        add_str("\n");
        text_q.push_back(8'd0);
        send_text();
        drain();

        random_sent = 0;
        while (random_sent < RANDOM_BYTES) begin
            if (random_sent >= RANDOM_BYTES - CALM_BYTES) calm = 1'b1;
            add_program();
            random_sent += text_q.size();
            if (!calm && $urandom_range(0, 7) == 0) drain();
            send_text();
        end
        s_axis_tvalid <= 1'b0;

        while (outstanding != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/tlx_pkg.sv
rtl/core/tlx_front.sv
rtl/core/tlx_queue.sv
rtl/core/tlx_back.sv
rtl/core/token_lexer_top.sv
tb/token_lexer_checker.sv
tb/testbench.sv
